[src/min_heap_event_queue_macros.svh]
// Assertion macros shared by the event queue modules.
`ifndef MIN_HEAP_EVENT_QUEUE_MACROS_SVH
`define MIN_HEAP_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define MHEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define MHEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mheq_pkg.sv]
// Types and constants of the min-heap event queue.
`timescale 1ns / 1ps
package mheq_pkg;

  localparam int CAPACITY = 1024;
  localparam int TAG_BITS = 16;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int OCC_W    = 11;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] removed_key;
    logic [TAG_W-1:0] removed_tag;
    logic [KEY_W-1:0] head_key;
    logic [TAG_W-1:0] head_tag;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    logic             fault;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD_INS,
    CMD_LOAD_DEL,
    CMD_FAULT,
    CMD_DEL_LOAD,
    CMD_UP_READ,
    CMD_UP_MOVE,
    CMD_DN_READ,
    CMD_DN_MOVE,
    CMD_PLACE,
    CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic leaf;
    logic up_less;
    logic dn_greater;
  } status_t;

endpackage

[src/min_heap_event_queue.sv]
// Insert: the new item sifts up k levels from the last slot (k <= 10), then is placed.
// Delete: the last entry moves to the root and sifts down k levels (k <= 9).
// One item at a time; each heap level moved costs a memory read followed by a
// compare-and-write step. busy drops in the strobe cycle.
// Reset: synchronous active-low rst_n empties the queue; heap memory is not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
module min_heap_event_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mheq_pkg::in_t  in_data,
  output logic           out_valid,
  output mheq_pkg::out_t out_data
);
  import mheq_pkg::*;

  cmd_t    cmd;
  status_t status;

  mheq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_data.action),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mheq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[src/mheq_ctrl.sv]
// Controller state machine that sequences inserts, deletes and sifts.
`timescale 1ns / 1ps
`include "min_heap_event_queue_macros.svh"
module mheq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             action,
  input  mheq_pkg::status_t status,
  output logic             busy,
  output logic             out_valid,
  output mheq_pkg::cmd_t   cmd
);
  import mheq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_TEST,
    S_UP_CMP,
    S_DEL_WAIT,
    S_DN_TEST,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = CMD_NONE;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_INSERT) begin
            if (status.full) begin
              cmd       = CMD_FAULT;
              state_nxt = S_DONE;
            end else begin
              cmd       = CMD_LOAD_INS;
              state_nxt = S_UP_TEST;
            end
          end else begin
            if (status.empty) begin
              cmd       = CMD_FAULT;
              state_nxt = S_DONE;
            end else begin
              cmd       = CMD_LOAD_DEL;
              state_nxt = S_DEL_WAIT;
            end
          end
        end
      end
      S_UP_TEST: begin
        if (status.at_root) begin
          cmd       = CMD_PLACE;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_UP_READ;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status.up_less) begin
          cmd       = CMD_UP_MOVE;
          state_nxt = S_UP_TEST;
        end else begin
          cmd       = CMD_PLACE;
          state_nxt = S_DONE;
        end
      end
      S_DEL_WAIT: begin
        // last entry is in the read register; count is already decremented
        cmd       = CMD_DEL_LOAD;
        state_nxt = status.empty ? S_DONE : S_DN_TEST;
      end
      S_DN_TEST: begin
        if (status.leaf) begin
          cmd       = CMD_PLACE;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_DN_READ;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (status.dn_greater) begin
          cmd       = CMD_DN_MOVE;
          state_nxt = S_DN_TEST;
        end else begin
          cmd       = CMD_PLACE;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd           = CMD_PUBLISH;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `MHEQ_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe longer than one cycle")
  `MHEQ_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE, "result shown while still working")
  `MHEQ_ASSERT_NEXT(a_accept_busy, start && (state_r == S_IDLE), state_r != S_IDLE, "accepted item not started")

endmodule

[src/mheq_dp.sv]
// Datapath: heap memory, sift position, head copy and result register.
`timescale 1ns / 1ps
`include "min_heap_event_queue_macros.svh"
module mheq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mheq_pkg::in_t     in_data,
  input  mheq_pkg::cmd_t    cmd,
  output mheq_pkg::status_t status,
  output mheq_pkg::out_t    out_data
);
  import mheq_pkg::*;

  entry_t mem [CAPACITY];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  pos_r;
  entry_t            item_r;
  entry_t            removed_r;
  entry_t            head_r;
  logic              fault_r;
  out_t              out_r;
  entry_t            rd_a_r;
  entry_t            rd_b_r;

  logic [CNT_W:0]    child_l;
  logic [CNT_W:0]    child_rgt;
  logic              right_ok;
  logic              pick_right;
  entry_t            pick;
  logic [CNT_W-1:0]  pick_idx;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_a_addr;
  logic [ADDR_W-1:0] rd_b_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  entry_t            in_entry;

  assign in_entry = '{key: in_data.key, tag: TAG_BITS'(in_data.tag)};

  // children of the current slot, one-based
  assign child_l   = {pos_r, 1'b0};
  assign child_rgt = {pos_r, 1'b1};
  assign right_ok  = (child_rgt <= {1'b0, count_r});

  // left child wins only on a strictly smaller key
  assign pick_right = right_ok && !(rd_a_r.key < rd_b_r.key);
  assign pick       = pick_right ? rd_b_r : rd_a_r;
  assign pick_idx   = pick_right ? CNT_W'(child_rgt) : CNT_W'(child_l);

  assign status.full       = (count_r == CNT_W'(CAPACITY));
  assign status.empty      = (count_r == '0);
  assign status.at_root    = (pos_r == CNT_W'(1));
  assign status.leaf       = (child_l > {1'b0, count_r});
  assign status.up_less    = (item_r.key < rd_a_r.key);
  assign status.dn_greater = (item_r.key > pick.key);

  always_comb begin
    rd_en     = 1'b0;
    rd_a_addr = ADDR_W'(child_l - 1'b1);
    rd_b_addr = ADDR_W'(child_l);
    we        = 1'b0;
    wdata     = item_r;
    unique case (cmd)
      CMD_LOAD_DEL: begin
        rd_en     = 1'b1;
        rd_a_addr = ADDR_W'(count_r - 1'b1);
      end
      CMD_UP_READ: begin
        rd_en     = 1'b1;
        rd_a_addr = ADDR_W'((pos_r >> 1) - 1'b1);
      end
      CMD_DN_READ: begin
        rd_en = 1'b1;
      end
      CMD_UP_MOVE: begin
        we    = 1'b1;
        wdata = rd_a_r;
      end
      CMD_DN_MOVE: begin
        we    = 1'b1;
        wdata = pick;
      end
      CMD_PLACE: begin
        we    = 1'b1;
        wdata = item_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign waddr = ADDR_W'(pos_r - 1'b1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd == CMD_LOAD_INS) begin
      count_r <= count_r + 1'b1;
    end else if (cmd == CMD_LOAD_DEL) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD_INS: begin
        item_r    <= in_entry;
        pos_r     <= count_r + 1'b1;
        removed_r <= '0;
        fault_r   <= 1'b0;
      end
      CMD_LOAD_DEL: begin
        removed_r <= head_r;
        fault_r   <= 1'b0;
      end
      CMD_FAULT: begin
        removed_r <= '0;
        fault_r   <= 1'b1;
      end
      CMD_DEL_LOAD: begin
        item_r <= rd_a_r;
        pos_r  <= CNT_W'(1);
      end
      CMD_UP_MOVE: begin
        pos_r <= pos_r >> 1;
      end
      CMD_DN_MOVE: begin
        pos_r <= pick_idx;
      end
      CMD_PUBLISH: begin
        out_r.removed_key <= removed_r.key;
        out_r.removed_tag <= TAG_W'(removed_r.tag);
        out_r.head_key    <= (count_r == '0) ? '0 : head_r.key;
        out_r.head_tag    <= (count_r == '0) ? '0 : TAG_W'(head_r.tag);
        out_r.occupancy   <= OCC_W'(count_r);
        out_r.is_empty    <= (count_r == '0);
        out_r.fault       <= fault_r;
      end
      default: begin
      end
    endcase
    // keep a copy of the root so the head needs no extra read
    if (we && (pos_r == CNT_W'(1))) begin
      head_r <= wdata;
    end
  end

  assign out_data = out_r;

  `MHEQ_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CNT_W'(CAPACITY), "occupancy above capacity")
  `MHEQ_ASSERT_NOW(a_write_live, we, (pos_r != '0) && (pos_r <= count_r), "write outside live slots")

endmodule

[tb/tb_min_heap_event_queue.sv]
// Self-checking testbench for the min-heap event queue: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_min_heap_event_queue;
  import mheq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  // typed expectation travels with the item it belongs to
  bit   typed_valid = 1'b0;
  out_t typed_out = '0;

  entry_t    heap_mem [1:CAPACITY];
  int        heap_size = 0;
  out_t      outcome_q [$];
  stim_row_t dir_rows [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        calm_left = 0;

  min_heap_event_queue DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("tb_min_heap_event_queue NOT OK");
    $finish;
  end

  task automatic flag_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag_mismatch($sformatf("%s: want %0h got %0h", name, want, got));
  endtask

  // Apply one item to the heap copy and return the result it should give.
  function automatic out_t heap_outcome(in_t item);
    out_t   r;
    entry_t tmp;
    int     pos;
    int     kid;
    bit     moving;
    r = '0;
    if (item.action == ACT_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.fault = 1'b1;
      end else begin
        heap_size++;
        heap_mem[heap_size].key = item.key;
        heap_mem[heap_size].tag = item.tag[TAG_BITS-1:0];
        pos = heap_size;
        // climb only on strictly smaller keys
        while (pos > 1 && heap_mem[pos].key < heap_mem[pos >> 1].key) begin
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[pos >> 1];
          heap_mem[pos >> 1] = tmp;
          pos = pos >> 1;
        end
      end
    end else begin
      if (heap_size == 0) begin
        r.fault = 1'b1;
      end else begin
        r.removed_key = heap_mem[1].key;
        r.removed_tag = TAG_W'(heap_mem[1].tag);
        heap_mem[1] = heap_mem[heap_size];
        heap_size--;
        pos = 1;
        moving = 1'b1;
        while (moving && 2 * pos <= heap_size) begin
          kid = 2 * pos;
          // left child wins only when strictly smaller
          if (kid + 1 <= heap_size && !(heap_mem[kid].key < heap_mem[kid + 1].key)) kid++;
          if (heap_mem[pos].key > heap_mem[kid].key) begin
            tmp = heap_mem[pos];
            heap_mem[pos] = heap_mem[kid];
            heap_mem[kid] = tmp;
            pos = kid;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end
    if (heap_size != 0) begin
      r.head_key = heap_mem[1].key;
      r.head_tag = TAG_W'(heap_mem[1].tag);
    end
    r.occupancy = OCC_W'(heap_size);
    r.is_empty = (heap_size == 0);
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    out_t want;
    out_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch("result with no item pending");
        end else begin
          want = outcome_q.pop_front();
          check_field("removed_key", want.removed_key, out_data.removed_key);
          check_field("removed_tag", 32'(want.removed_tag), 32'(out_data.removed_tag));
          check_field("head_key", want.head_key, out_data.head_key);
          check_field("head_tag", 32'(want.head_tag), 32'(out_data.head_tag));
          check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
          check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
          check_field("fault", 32'(want.fault), 32'(out_data.fault));
        end
      end
      if (start && !busy) begin
        pred = heap_outcome(in_data);
        outcome_q = {outcome_q, (typed_valid ? typed_out : pred)};
      end
    end
  end

  function automatic stim_row_t predicted_row(logic act, logic [KEY_W-1:0] key,
                                              logic [TAG_W-1:0] tag);
    stim_row_t row;
    row.item.action = act;
    row.item.key = key;
    row.item.tag = tag;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic act, logic [KEY_W-1:0] key,
                                          logic [TAG_W-1:0] tag,
                                          logic [KEY_W-1:0] rk, logic [TAG_W-1:0] rt,
                                          logic [KEY_W-1:0] hk, logic [TAG_W-1:0] ht,
                                          int occ, logic emp, logic flt);
    stim_row_t row;
    row = predicted_row(act, key, tag);
    row.typed = 1'b1;
    row.want.removed_key = rk;
    row.want.removed_tag = rt;
    row.want.head_key = hk;
    row.want.head_tag = ht;
    row.want.occupancy = OCC_W'(occ);
    row.want.is_empty = emp;
    row.want.fault = flt;
    return row;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic in_t random_item(int insert_pct);
    in_t item;
    item.action = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_DELETE;
    // narrow keys give plenty of ties
    item.key = ($urandom_range(0, 2) == 0) ? KEY_W'($urandom_range(0, 15)) : $urandom();
    item.tag = TAG_W'($urandom_range(0, 65535));
    return item;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(stim_row_t row);
    dir_rows = {dir_rows, row};
  endtask

  // Advance to the next falling edge, then drop start and wait out the gap if it is nonzero.
  task automatic next_slot(int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
  endtask

  // Present an item at a falling edge and hold it until accepted.
  task automatic drive(in_t item, bit typed, out_t want);
    in_data = item;
    typed_valid = typed;
    typed_out = want;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin : stimulus
    int i;
    add_row(typed_row(ACT_DELETE, '1, '1, 0, 0, 0, 0, 0, 1, 1));
    add_row(typed_row(ACT_INSERT, '1, '1, 0, 0, '1, '1, 1, 0, 0));
    add_row(typed_row(ACT_INSERT, 0, 0, 0, 0, 0, 0, 2, 0, 0));
    add_row(predicted_row(ACT_DELETE, 0, 0));
    add_row(typed_row(ACT_DELETE, 0, 0, '1, '1, 0, 0, 0, 1, 0));
    add_row(typed_row(ACT_DELETE, 32'h1234_5678, 16'hA5A5, 0, 0, 0, 0, 0, 1, 1));
    for (i = 1; i <= 5; i++) add_row(predicted_row(ACT_INSERT, 7, TAG_W'(i)));
    add_row(predicted_row(ACT_INSERT, 3, 6));
    add_row(predicted_row(ACT_INSERT, 7, 7));
    for (i = 0; i < 4; i++) add_row(predicted_row(ACT_DELETE, 0, 0));
    add_row(predicted_row(ACT_INSERT, 32'h8000_0000, 16'h8000));
    add_row(predicted_row(ACT_INSERT, 32'h7FFF_FFFF, 16'h7FFF));
    add_row(predicted_row(ACT_INSERT, 1, 1));
    add_row(predicted_row(ACT_INSERT, 32'hFFFF_FFFE, 16'hFFFE));
    add_row(predicted_row(ACT_DELETE, 0, 0));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[r]) begin
      next_slot(pick_gap());
      drive(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
    end

    // churn around a small heap, empty faults included
    for (i = 0; i < 200; i++) begin
      if (i == 100) hold_until_drained();
      else next_slot(pick_gap());
      drive(random_item(heap_size < 8 ? 60 : 45), 1'b0, '0);
    end

    // grow to full, then work at the full boundary
    while (heap_size < CAPACITY) begin
      next_slot(pick_gap());
      drive(random_item(95), 1'b0, '0);
    end
    for (i = 0; i < 60; i++) begin
      next_slot(pick_gap());
      drive(random_item(55), 1'b0, '0);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (outcome_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
    if (mismatch_count == 0) begin
      $display("tb_min_heap_event_queue OK");
    end else begin
      $display("tb_min_heap_event_queue NOT OK");
    end
    $finish;
  end

endmodule
